FILE: design/gsdp_pkg.sv
// gsdp_pkg: shared types and constants of the grid shortest dig path block
// used by the controller, the datapath and the top level
package gsdp_pkg;

	localparam int MAP_BITS = 5;
	localparam int MAP_SIDE = 1 << MAP_BITS;
	localparam int TILE_SHIFT = 5;
	localparam int IDX_W = 2 * MAP_BITS;
	localparam int NTILES = 1 << IDX_W;
	localparam int CNT_W = IDX_W + 1;
	localparam int COST_W = 28;
	localparam int ENTRY_W = 17;
	localparam int NODE_W = 2 + IDX_W + COST_W;
	localparam int DVD_W = 19;
	localparam int DIV_W = 7;
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_FIND = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FOUND = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [0:0] REG_TRAVEL = 1'd0;
	localparam logic [0:0] REG_DRILL = 1'd1;

	typedef enum logic [1:0] {RES_ZERO, RES_FOUND, RES_FAIL, RES_READ} res_t;

	typedef struct packed {
		logic capture;
		logic clr_entry;
		logic div_init;
		logic div_step;
		logic load_wr;
		logic cnt_clr;
		logic clr_node;
		logic init_start;
		logic rel_rd;
		logic rel_wr;
		logic scan_init;
		logic scan_step;
		logic settle;
		logic trace_init;
		logic trace_wr;
		logic trace_take;
		logic read_issue;
		logic fin;
		res_t res;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic div_last;
		logic off_map;
		logic same_tile;
		logic dir_last;
		logic found;
		logic best_is_target;
		logic trace_done;
		logic out_free;
	} sts_t;

endpackage

FILE: design/gsdp_ram.sv
// gsdp_ram: generic simple dual port memory with registered read
// no dependencies
module gsdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: design/gsdp_ctrl.sv
// gsdp_ctrl: sequencing state machine of the grid shortest dig path block
// depends on gsdp_pkg
module gsdp_ctrl import gsdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] opcode,
	input  sts_t       sts,
	output logic       in_stall,
	output cmd_t       cmd
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DIV, S_LWR, S_FCHK, S_FCLR, S_FINIT, S_RELRD, S_RELWR,
		S_SCAN, S_SCANEND, S_DECIDE, S_TCHK, S_TWAIT, S_RWAIT, S_FIN
	} state_t;

	state_t state_q;
	res_t res_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.res = res_q;
		case (state_q)
			S_CLEAR: cmd.clr_entry = 1'b1;
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.div_init = (opcode == OP_LOAD);
					cmd.read_issue = (opcode == OP_READ);
				end
			end
			S_DIV: cmd.div_step = 1'b1;
			S_LWR: cmd.load_wr = 1'b1;
			S_FCHK: cmd.cnt_clr = !sts.off_map;
			S_FCLR: cmd.clr_node = 1'b1;
			S_FINIT: begin
				cmd.init_start = 1'b1;
				cmd.trace_init = sts.same_tile;
			end
			S_RELRD: cmd.rel_rd = 1'b1;
			S_RELWR: begin
				cmd.rel_wr = 1'b1;
				cmd.scan_init = sts.dir_last;
			end
			S_SCAN: cmd.scan_step = 1'b1;
			S_DECIDE: begin
				cmd.settle = sts.found;
				cmd.trace_init = sts.found && sts.best_is_target;
			end
			S_TCHK: cmd.trace_wr = !sts.trace_done;
			S_TWAIT: cmd.trace_take = 1'b1;
			S_FIN: cmd.fin = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q <= RES_ZERO;
		end else begin
			case (state_q)
				S_CLEAR: if (sts.cnt_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid) begin
						case (opcode)
							OP_LOAD: state_q <= S_DIV;
							OP_FIND: state_q <= S_FCHK;
							OP_READ: state_q <= S_RWAIT;
							default: begin
								res_q <= RES_ZERO;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_DIV: if (sts.div_last) state_q <= S_LWR;
				S_LWR: begin
					res_q <= RES_ZERO;
					state_q <= S_FIN;
				end
				S_FCHK: begin
					if (sts.off_map) begin
						res_q <= RES_FAIL;
						state_q <= S_FIN;
					end else begin
						state_q <= S_FCLR;
					end
				end
				S_FCLR: if (sts.cnt_last) state_q <= S_FINIT;
				S_FINIT: state_q <= sts.same_tile ? S_TCHK : S_RELRD;
				S_RELRD: state_q <= S_RELWR;
				S_RELWR: state_q <= sts.dir_last ? S_SCAN : S_RELRD;
				S_SCAN: if (sts.cnt_last) state_q <= S_SCANEND;
				S_SCANEND: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (!sts.found) begin
						res_q <= RES_FAIL;
						state_q <= S_FIN;
					end else begin
						state_q <= sts.best_is_target ? S_TCHK : S_RELRD;
					end
				end
				S_TCHK: begin
					if (sts.trace_done) begin
						res_q <= RES_FOUND;
						state_q <= S_FIN;
					end else begin
						state_q <= S_TWAIT;
					end
				end
				S_TWAIT: state_q <= S_TCHK;
				S_RWAIT: begin
					res_q <= RES_READ;
					state_q <= S_FIN;
				end
				S_FIN: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/gsdp_dp.sv
// gsdp_dp: datapath with tile cost, node and path memories, divider and result register
// depends on gsdp_pkg and gsdp_ram
module gsdp_dp import gsdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data,
	input  logic [IDX_W-1:0]   tile_index,
	input  logic               tile_solid,
	input  logic [15:0]        tile_health,
	input  logic [9:0]         start_x,
	input  logic [9:0]         start_y,
	input  logic [7:0]         body_width,
	input  logic [7:0]         body_height,
	input  logic [9:0]         target_x,
	input  logic [9:0]         target_y,
	input  logic [9:0]         step_index,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic [10:0]        path_length,
	output logic [9:0]         path_tile,
	output logic [COST_W-1:0]  total_cost
);
	logic [15:0] travel_q;
	logic [3:0] drill_q;
	logic [IDX_W-1:0] tidx_q;
	logic solid_q;
	logic [9:0] sx_q, sy_q, tx_q, ty_q, step_q;
	logic [7:0] bw_q, bh_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DIV_W-1:0] rem_q;
	logic [IDX_W-1:0] u_q, nb_q, bidx_q, t_q;
	logic [COST_W-1:0] ubest_q, bc_q;
	logic [IDX_W-1:0] bcame_q;
	logic [1:0] dir_q;
	logic rel_pend_q, found_q;
	logic scan_v_s1;
	logic [IDX_W-1:0] scan_idx_s1;
	logic [CNT_W-1:0] stored_len_q;

	logic [10:0] cx, cy;
	logic [5:0] sc, sr, tc, tr;
	logic [IDX_W-1:0] start_t, target_t, col, row, nb;
	logic nb_ok;
	logic [DIV_W-1:0] divisor;
	logic [DIV_W:0] part;
	logic ge;
	logic [ENTRY_W-1:0] entry_val;
	logic [COST_W:0] sum;
	logic [COST_W-1:0] nd;

	logic e_we, n_we, p_we, n_re, p_re;
	logic [IDX_W-1:0] e_waddr, n_waddr, n_raddr, p_raddr;
	logic [ENTRY_W-1:0] e_wdata, e_rdata;
	logic [NODE_W-1:0] n_wdata, n_rdata;
	logic [IDX_W-1:0] p_rdata;

	logic n_reached, n_settled;
	logic [IDX_W-1:0] n_came;
	logic [COST_W-1:0] n_best;

	assign cx = {1'b0, sx_q} + {4'b0, bw_q[7:1]};
	assign cy = {1'b0, sy_q} + {4'b0, bh_q[7:1]};
	assign sc = cx[10:TILE_SHIFT];
	assign sr = cy[10:TILE_SHIFT];
	assign tc = {1'b0, tx_q[9:TILE_SHIFT]};
	assign tr = {1'b0, ty_q[9:TILE_SHIFT]};
	assign start_t = {sr[MAP_BITS-1:0], sc[MAP_BITS-1:0]};
	assign target_t = {tr[MAP_BITS-1:0], tc[MAP_BITS-1:0]};

	assign col = {{MAP_BITS{1'b0}}, u_q[MAP_BITS-1:0]};
	assign row = {{MAP_BITS{1'b0}}, u_q[IDX_W-1:MAP_BITS]};

	always_comb begin
		nb = u_q;
		nb_ok = 1'b0;
		case (dir_q)
			2'd0: begin
				nb_ok = (col != IDX_W'(MAP_SIDE - 1));
				nb = u_q + IDX_W'(1);
			end
			2'd1: begin
				nb_ok = (row != '0);
				nb = u_q - IDX_W'(MAP_SIDE);
			end
			2'd2: begin
				nb_ok = (col != '0);
				nb = u_q - IDX_W'(1);
			end
			default: begin
				nb_ok = (row != IDX_W'(MAP_SIDE - 1));
				nb = u_q + IDX_W'(MAP_SIDE);
			end
		endcase
	end

	assign divisor = DIV_W'(10) + {1'b0, drill_q, 2'b0};
	assign part = {rem_q, dvd_q[DVD_W-1]};
	assign ge = (part >= {1'b0, divisor});
	assign entry_val = {1'b0, travel_q} + (solid_q ? {2'b0, dvd_q[14:0]} : '0);

	assign {n_reached, n_settled, n_came, n_best} = n_rdata;
	assign sum = {1'b0, ubest_q} + {{(COST_W+1-ENTRY_W){1'b0}}, e_rdata};
	assign nd = (sum > {1'b0, COST_MAX}) ? COST_MAX : sum[COST_W-1:0];

	assign sts.cnt_last = (cnt_q[IDX_W-1:0] == IDX_W'(NTILES - 1));
	assign sts.div_last = (cnt_q == CNT_W'(DVD_W - 1));
	assign sts.off_map = sc[MAP_BITS] | sr[MAP_BITS] | tc[MAP_BITS] | tr[MAP_BITS];
	assign sts.same_tile = (start_t == target_t);
	assign sts.dir_last = (dir_q == 2'd3);
	assign sts.found = found_q;
	assign sts.best_is_target = (bidx_q == target_t);
	assign sts.trace_done = (t_q == start_t) || (cnt_q == CNT_W'(NTILES));
	assign sts.out_free = !out_valid || !out_stall;

	always_comb begin
		e_we = cmd.clr_entry || (cmd.load_wr && ({1'b0, tidx_q} < CNT_W'(NTILES)));
		e_waddr = cmd.clr_entry ? cnt_q[IDX_W-1:0] : tidx_q;
		e_wdata = cmd.clr_entry ? '0 : entry_val;
		n_we = 1'b0;
		n_waddr = cnt_q[IDX_W-1:0];
		n_wdata = '0;
		if (cmd.init_start) begin
			n_we = 1'b1;
			n_waddr = start_t;
			n_wdata = {2'b11, start_t, {COST_W{1'b0}}};
		end else if (cmd.rel_wr) begin
			n_we = rel_pend_q && !n_settled && (!n_reached || nd < n_best);
			n_waddr = nb_q;
			n_wdata = {2'b10, u_q, nd};
		end else if (cmd.settle) begin
			n_we = 1'b1;
			n_waddr = bidx_q;
			n_wdata = {2'b11, bcame_q, bc_q};
		end else if (cmd.clr_node) begin
			n_we = 1'b1;
		end
		n_re = cmd.scan_step || cmd.rel_rd || cmd.trace_wr;
		n_raddr = cmd.scan_step ? cnt_q[IDX_W-1:0] : (cmd.rel_rd ? nb : t_q);
		p_we = cmd.trace_wr;
		p_re = cmd.read_issue;
		p_raddr = step_index;
	end

	gsdp_ram #(.WIDTH(ENTRY_W), .DEPTH(NTILES)) u_entry (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.re(cmd.rel_rd), .raddr(nb), .rdata(e_rdata)
	);

	gsdp_ram #(.WIDTH(NODE_W), .DEPTH(NTILES)) u_node (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.re(n_re), .raddr(n_raddr), .rdata(n_rdata)
	);

	gsdp_ram #(.WIDTH(IDX_W), .DEPTH(NTILES)) u_path (
		.clk(clk), .we(p_we), .waddr(cnt_q[IDX_W-1:0]), .wdata(t_q),
		.re(p_re), .raddr(p_raddr), .rdata(p_rdata)
	);

	// config and item fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q <= 16'd1;
			drill_q <= '0;
		end else if (wr_en) begin
			if (wr_index == {1'b0, REG_TRAVEL}) travel_q <= wr_data;
			if (wr_index == {1'b0, REG_DRILL}) drill_q <= wr_data[3:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tidx_q <= tile_index;
			solid_q <= tile_solid;
			sx_q <= start_x;
			sy_q <= start_y;
			bw_q <= body_width;
			bh_q <= body_height;
			tx_q <= target_x;
			ty_q <= target_y;
			step_q <= step_index;
		end
		if (cmd.div_init) begin
			dvd_q <= {1'b0, tile_health, 2'b0} + {3'b0, tile_health};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? DIV_W'(part - {1'b0, divisor}) : part[DIV_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
		if (cmd.init_start) begin
			u_q <= start_t;
			ubest_q <= '0;
		end else if (cmd.settle) begin
			u_q <= bidx_q;
			ubest_q <= bc_q;
		end
		if (cmd.rel_rd) begin
			nb_q <= nb;
			rel_pend_q <= nb_ok;
		end
		scan_idx_s1 <= cnt_q[IDX_W-1:0];
		if (scan_v_s1 && n_reached && !n_settled && (!found_q || n_best < bc_q)) begin
			bidx_q <= scan_idx_s1;
			bc_q <= n_best;
			bcame_q <= n_came;
		end
		if (cmd.trace_init) begin
			t_q <= target_t;
		end else if (cmd.trace_take) begin
			t_q <= n_came;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dir_q <= '0;
			found_q <= 1'b0;
			scan_v_s1 <= 1'b0;
			stored_len_q <= '0;
			out_valid <= 1'b0;
			status <= ST_OK;
			path_length <= '0;
			path_tile <= '0;
			total_cost <= '0;
		end else begin
			scan_v_s1 <= cmd.scan_step;
			if (cmd.div_init || cmd.cnt_clr || cmd.scan_init || cmd.trace_init) begin
				cnt_q <= '0;
			end else if (cmd.clr_entry || cmd.div_step || cmd.clr_node || cmd.scan_step
					|| cmd.trace_wr) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.init_start || cmd.settle) begin
				dir_q <= '0;
			end else if (cmd.rel_wr) begin
				dir_q <= dir_q + 2'd1;
			end
			if (cmd.scan_init) begin
				found_q <= 1'b0;
			end else if (scan_v_s1 && n_reached && !n_settled) begin
				found_q <= 1'b1;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (cmd.fin) begin
				out_valid <= 1'b1;
				status <= ST_OK;
				path_length <= '0;
				path_tile <= '0;
				total_cost <= '0;
				case (cmd.res)
					RES_FOUND: begin
						status <= ST_FOUND;
						stored_len_q <= cnt_q;
						path_length <= cnt_q;
						path_tile <= target_t;
						total_cost <= ubest_q;
					end
					RES_FAIL: begin
						status <= ST_FAIL;
						stored_len_q <= '0;
					end
					RES_READ: begin
						path_length <= stored_len_q;
						if ({1'b0, step_q} < stored_len_q) begin
							path_tile <= p_rdata;
						end else begin
							status <= ST_RANGE;
						end
					end
					default: status <= ST_OK;
				endcase
			end
		end
	end
endmodule

FILE: design/grid_shortest_dig_path_top.sv
// grid_shortest_dig_path_top: top level of the grid shortest dig path block
// depends on gsdp_pkg, gsdp_ctrl, gsdp_dp
//
// Input beats carry an opcode: load tile cost, find path, read path step.
// Every input beat gives exactly one output beat. in_stall is high while an
// item is at work; out_valid holds a result until a cycle with out_stall low.
// The next item may be accepted while a result still waits, but its result
// is only written once the output register is free.
// A load computes one quotient bit per cycle over 19 bits. A find clears
// all 1024 entries of the node memory, then per settled tile relaxes its
// neighbours and scans every entry through the single node memory read
// port, then traces the path one step at a time back to the start.
// After reset all 1024 entries of the tile cost memory are cleared with
// in_stall high; configuration writes are taken at any time.
module grid_shortest_dig_path_top import gsdp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [15:0]       wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [9:0]        tile_index,
	input  logic              tile_solid,
	input  logic [15:0]       tile_health,
	input  logic [9:0]        start_x,
	input  logic [9:0]        start_y,
	input  logic [7:0]        body_width,
	input  logic [7:0]        body_height,
	input  logic [9:0]        target_x,
	input  logic [9:0]        target_y,
	input  logic [9:0]        step_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [10:0]       path_length,
	output logic [9:0]        path_tile,
	output logic [27:0]       total_cost
);
	cmd_t cmd;
	sts_t sts;

	gsdp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .opcode(opcode),
		.sts(sts), .in_stall(in_stall), .cmd(cmd)
	);

	gsdp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.tile_index(tile_index), .tile_solid(tile_solid), .tile_health(tile_health),
		.start_x(start_x), .start_y(start_y), .body_width(body_width),
		.body_height(body_height), .target_x(target_x), .target_y(target_y),
		.step_index(step_index), .out_stall(out_stall), .out_valid(out_valid),
		.status(status), .path_length(path_length), .path_tile(path_tile),
		.total_cost(total_cost)
	);
endmodule

FILE: verif/grid_shortest_dig_path_top_tb.sv
// grid_shortest_dig_path_top_tb: self-checking testbench of the grid shortest dig path block
// depends on gsdp_pkg and grid_shortest_dig_path_top; a behavioural path search
// predicts every result beat, which is checked in order against the output channel
`timescale 1ns / 100ps

module grid_shortest_dig_path_top_tb import gsdp_pkg::*;;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int LO = 13;
	localparam int HI = 16;

	typedef struct {
		logic [1:0]  op;
		logic [9:0]  idx;
		logic        solid;
		logic [15:0] health;
		logic [9:0]  sx;
		logic [9:0]  sy;
		logic [7:0]  bw;
		logic [7:0]  bh;
		logic [9:0]  tx;
		logic [9:0]  ty;
		logic [9:0]  step;
	} item_t;

	typedef struct {
		logic [1:0]  st;
		logic [10:0] len;
		logic [9:0]  tile;
		logic [27:0] cost;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [1:0] wr_index = '0;
	logic [15:0] wr_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] opcode = '0;
	logic [9:0] tile_index = '0;
	logic tile_solid = 0;
	logic [15:0] tile_health = '0;
	logic [9:0] start_x = '0;
	logic [9:0] start_y = '0;
	logic [7:0] body_width = '0;
	logic [7:0] body_height = '0;
	logic [9:0] target_x = '0;
	logic [9:0] target_y = '0;
	logic [9:0] step_index = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status;
	logic [10:0] path_length;
	logic [9:0] path_tile;
	logic [27:0] total_cost;

	// predictor state
	logic [16:0] tile_cost [NTILES];
	logic [27:0] best_dist [NTILES];
	int unsigned parent [NTILES];
	bit done_tile [NTILES];
	bit seen_tile [NTILES];
	logic [9:0] route [NTILES];
	int unsigned route_len = 0;
	logic [15:0] cfg_travel = 16'd1;
	logic [3:0] cfg_drill = 4'd0;

	result_t pending_results [$];
	int errors = 0;
	int cycles = 0;
	bit calm = 0;

	grid_shortest_dig_path_top dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: st %0d len %0d tile %0d cost %0d",
						status, path_length, path_tile, total_cost);
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st || path_length !== exp_r.len ||
				    path_tile !== exp_r.tile || total_cost !== exp_r.cost) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp st %0d len %0d tile %0d cost %0d,",
							" got st %0d len %0d tile %0d cost %0d"},
							exp_r.st, exp_r.len, exp_r.tile, exp_r.cost,
							status, path_length, path_tile, total_cost);
				end
			end
		end
	end

	function automatic void relax_tile(int unsigned from, int unsigned to);
		logic [31:0] nd;
		if (done_tile[to])
			return;
		nd = 32'(best_dist[from]) + 32'(tile_cost[to]);
		if (nd > 32'(COST_MAX))
			nd = 32'(COST_MAX);
		if (!seen_tile[to] || nd[27:0] < best_dist[to]) begin
			seen_tile[to] = 1;
			best_dist[to] = nd[27:0];
			parent[to] = from;
		end
	endfunction

	function automatic bit dig_search(int unsigned src, int unsigned dst);
		int unsigned u, col, row, pick, t;
		bit found;
		logic [27:0] low;
		for (int i = 0; i < NTILES; i++) begin
			done_tile[i] = 0;
			seen_tile[i] = 0;
		end
		best_dist[src] = 0;
		parent[src] = src;
		seen_tile[src] = 1;
		done_tile[src] = 1;
		u = src;
		while (!done_tile[dst]) begin
			col = u % MAP_SIDE;
			row = u / MAP_SIDE;
			if (col + 1 < MAP_SIDE) relax_tile(u, u + 1);
			if (row > 0) relax_tile(u, u - MAP_SIDE);
			if (col > 0) relax_tile(u, u - 1);
			if (row + 1 < MAP_SIDE) relax_tile(u, u + MAP_SIDE);
			found = 0;
			pick = 0;
			low = '0;
			for (int i = 0; i < NTILES; i++)
				if (seen_tile[i] && !done_tile[i] && (!found || best_dist[i] < low)) begin
					found = 1;
					pick = i;
					low = best_dist[i];
				end
			if (!found)
				return 0;
			done_tile[pick] = 1;
			u = pick;
		end
		route_len = 0;
		t = dst;
		while (t != src && route_len < NTILES) begin
			route[route_len] = t[9:0];
			route_len++;
			t = parent[t] % NTILES;
		end
		return 1;
	endfunction

	function automatic result_t predict_beat(item_t it);
		result_t r;
		int unsigned c, cx, cy, sc, sr, tc, tr, src, dst;
		r = '{ST_OK, '0, '0, '0};
		if (it.op == OP_LOAD) begin
			c = cfg_travel;
			if (it.solid)
				c += (32'(it.health) * 5) / (10 + 4 * cfg_drill);
			tile_cost[it.idx] = c[16:0];
		end else if (it.op == OP_FIND) begin
			cx = it.sx + it.bw / 2;
			cy = it.sy + it.bh / 2;
			sc = cx / 32;
			sr = cy / 32;
			tc = it.tx / 32;
			tr = it.ty / 32;
			route_len = 0;
			r.st = ST_FAIL;
			if (sc < MAP_SIDE && sr < MAP_SIDE && tc < MAP_SIDE && tr < MAP_SIDE) begin
				src = sr * MAP_SIDE + sc;
				dst = tr * MAP_SIDE + tc;
				if (dig_search(src, dst)) begin
					r.st = ST_FOUND;
					r.len = route_len[10:0];
					r.tile = dst[9:0];
					r.cost = best_dist[dst];
				end else
					route_len = 0;
			end
		end else if (it.op == OP_READ) begin
			r.len = route_len[10:0];
			if (it.step < route_len)
				r.tile = route[it.step];
			else
				r.st = ST_RANGE;
		end
		return r;
	endfunction

	function automatic item_t rand_item(logic [1:0] op);
		item_t it;
		it.op = op;
		it.idx = 10'($urandom);
		it.solid = 1'($urandom);
		it.health = 16'($urandom);
		it.sx = 10'($urandom);
		it.sy = 10'($urandom);
		it.bw = 8'($urandom);
		it.bh = 8'($urandom);
		it.tx = 10'($urandom);
		it.ty = 10'($urandom);
		it.step = 10'($urandom);
		return it;
	endfunction

	task automatic send_beat(item_t it);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 33) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		opcode <= it.op;
		tile_index <= it.idx;
		tile_solid <= it.solid;
		tile_health <= it.health;
		start_x <= it.sx;
		start_y <= it.sy;
		body_width <= it.bw;
		body_height <= it.bh;
		target_x <= it.tx;
		target_y <= it.ty;
		step_index <= it.step;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.insert(pending_results.size(), predict_beat(it));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [15:0] value);
		@(negedge clk);
		wr_en <= 1;
		wr_index <= index;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 0;
		if (index == 2'(REG_TRAVEL))
			cfg_travel = value;
		else if (index == 2'(REG_DRILL))
			cfg_drill = value[3:0];
	endtask

	task automatic load_tile(int unsigned t, bit solid, logic [15:0] health);
		item_t it;
		it = rand_item(OP_LOAD);
		it.idx = t[9:0];
		it.solid = solid;
		it.health = health;
		send_beat(it);
	endtask

	task automatic find_tiles(int unsigned sc, int unsigned sr, int unsigned tc, int unsigned tr);
		item_t it;
		it = rand_item(OP_FIND);
		it.sx = 10'(sc * 32 + $urandom_range(31) - it.bw / 2);
		it.sy = 10'(sr * 32 + $urandom_range(31) - it.bh / 2);
		it.tx = 10'(tc * 32 + $urandom_range(31));
		it.ty = 10'(tr * 32 + $urandom_range(31));
		send_beat(it);
	endtask

	task automatic read_step(logic [9:0] s);
		item_t it;
		it = rand_item(OP_READ);
		it.step = s;
		send_beat(it);
	endtask

	task automatic test_load_extremes();
		write_reg(2'(REG_TRAVEL), 16'hFFFF);
		write_reg(2'(REG_DRILL), 16'd15);
		load_tile(0, 1'b1, 16'hFFFF);
		load_tile(1, 1'b1, 16'h0000);
		drain();
		write_reg(2'(REG_TRAVEL), 16'h0000);
		write_reg(2'(REG_DRILL), 16'd0);
		load_tile(1023, 1'b0, 16'hFFFF);
		load_tile(992, 1'b1, 16'hFFFF);
		load_tile(31, 1'b1, 16'h0001);
		drain();
		write_reg(2'(REG_TRAVEL), 16'd1);
	endtask

	task automatic test_find_special();
		item_t it;
		// start and target on one tile
		it = rand_item(OP_FIND);
		it.sx = 10'd100; it.bw = 8'd8; it.sy = 10'd200; it.bh = 8'd0;
		it.tx = 10'd96; it.ty = 10'd223;
		send_beat(it);
		// body centre past the right edge
		it = rand_item(OP_FIND);
		it.sx = 10'd1023; it.bw = 8'd255; it.sy = 10'd0; it.bh = 8'd0;
		send_beat(it);
		// body centre past the bottom edge
		it = rand_item(OP_FIND);
		it.sx = 10'd0; it.bw = 8'd0; it.sy = 10'd1000; it.bh = 8'd64;
		send_beat(it);
		read_step(10'd0);
		// corner to corner across the whole map
		it = rand_item(OP_FIND);
		it.sx = 10'd0; it.bw = 8'd1; it.sy = 10'd0; it.bh = 8'd1;
		it.tx = 10'd1023; it.ty = 10'd1023;
		send_beat(it);
	endtask

	task automatic test_read_steps();
		read_step(10'd0);
		read_step(10'(route_len - 1));
		read_step(10'(route_len));
		read_step(10'd1023);
		send_beat(rand_item(OP_SPARE));
	endtask

	// expensive ring around a small working area keeps searches local
	task automatic build_ring();
		drain();
		write_reg(2'(REG_TRAVEL), 16'hFFFF);
		write_reg(2'(REG_DRILL), 16'd0);
		for (int r = LO - 1; r <= HI + 1; r++)
			for (int c = LO - 1; c <= HI + 1; c++)
				if (r < LO || r > HI || c < LO || c > HI)
					load_tile(r * MAP_SIDE + c, 1'b1, 16'hFFFF);
	endtask

	task automatic fill_area(logic [15:0] travel, logic [3:0] drill);
		drain();
		write_reg(2'(REG_TRAVEL), travel);
		write_reg(2'(REG_DRILL), 16'(drill));
		for (int r = LO; r <= HI; r++)
			for (int c = LO; c <= HI; c++)
				load_tile(r * MAP_SIDE + c, 1'($urandom), 16'($urandom));
	endtask

	task automatic random_mix(int n);
		item_t it;
		int unsigned pick, r, c;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				find_tiles($urandom_range(LO, HI), $urandom_range(LO, HI),
					$urandom_range(LO, HI), $urandom_range(LO, HI));
			end else if (pick < 70) begin
				read_step($urandom_range(9) == 0 ? 10'($urandom) :
					10'($urandom_range(route_len)));
			end else if (pick < 82) begin
				load_tile($urandom_range(LO, HI) * MAP_SIDE + $urandom_range(LO, HI),
					1'($urandom), 16'($urandom));
			end else if (pick < 92) begin
				// load well away from the working area
				it = rand_item(OP_LOAD);
				r = it.idx / MAP_SIDE;
				c = it.idx % MAP_SIDE;
				if (r >= LO - 1 && r <= HI + 1 && c >= LO - 1 && c <= HI + 1)
					it.idx[9] = ~it.idx[9];
				send_beat(it);
			end else if (pick < 96) begin
				it = rand_item(OP_FIND);
				it.sx = 10'($urandom_range(1023 - 127, 1023));
				it.bw = 8'($urandom_range(255, 254));
				send_beat(it);
			end else
				send_beat(rand_item(OP_SPARE));
		end
	endtask

	task automatic test_random();
		build_ring();
		fill_area(16'($urandom_range(1, 300)), 4'($urandom_range(8, 15)));
		random_mix(12);
		fill_area(16'd0, 4'd15);
		calm = 1;
		random_mix(10);
		calm = 0;
		random_mix(8);
	endtask

	initial begin
		for (int i = 0; i < NTILES; i++)
			tile_cost[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		test_load_extremes();
		test_find_special();
		test_read_steps();
		test_random();
		drain();
		repeat (30) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
